// ----- rtl/core/htoi_pkg.sv -----
// Package for the hex text to integer parser: shared types, character codes
// and the character classifier. No dependencies.
`default_nettype none

package htoi_pkg;

    localparam int unsigned DEF_MAX_DIGITS = 16;
    localparam int unsigned CHAR_W         = 8;
    localparam int unsigned VALUE_W        = 64;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;  // 'x'
    localparam logic [CHAR_W-1:0] CH_H     = 8'h68;  // 'h'
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              terminator;
    } t_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ok;
    } t_result;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] digit;
    } t_hex;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_hex hex_decode(input logic [CHAR_W-1:0] c);
        t_hex h;
        h.is_hex = 1'b0;
        h.digit  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.is_hex = 1'b1;
            h.digit  = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.is_hex = 1'b1;
            h.digit  = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/htoi_if.sv -----
// Handshake channels of the parser: input character items and result items.
// Depends on htoi_pkg.
`default_nettype none

interface htoi_in_if;
    import htoi_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              terminator;

    modport source (output valid, character, terminator, input ready);
    modport sink   (input valid, character, terminator, output ready);
endinterface

interface htoi_out_if;
    import htoi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      ok;

    modport source (output valid, value, ok, input ready);
    modport sink   (input valid, value, ok, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/htoi_in_stage.sv -----
// Input register of the parser: holds one character item until the parse
// step takes it. Depends on htoi_pkg.
`default_nettype none

module htoi_in_stage
    import htoi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_ready,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- rtl/core/htoi_parse.sv -----
// Parse state of the hex text parser: phase, sign, accumulator, digit count
// and error flag, updated once per item. Depends on htoi_pkg.
`default_nettype none

module htoi_parse
    import htoi_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    output t_result    o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_ZERO1,
        PH_X,
        PH_ZEROS,
        PH_BODY,
        PH_AFTER
    } t_phase;

    t_phase             r_phase,  n_phase;
    logic               r_neg,    n_neg;
    logic [VALUE_W-1:0] r_acc,    n_acc;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               r_failed, n_failed;

    logic [CHAR_W-1:0] c;
    logic              blank;
    t_hex              hx;
    logic              good;

    assign c     = i_item.character;
    assign blank = is_blank(c);
    assign hx    = hex_decode(c);
    assign good  = !r_failed && (r_phase != PH_X);

    always_comb begin
        o_result.ok    = good;
        o_result.value = '0;
        if (good) begin
            o_result.value = r_neg ? (-r_acc) : r_acc;
        end
    end

    always_comb begin
        logic body;
        body     = 1'b0;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_count  = r_count;
        n_failed = r_failed;
        if (i_item.terminator) begin
            n_phase  = PH_LEAD;
            n_neg    = 1'b0;
            n_acc    = '0;
            n_count  = '0;
            n_failed = 1'b0;
        end else if (!r_failed) begin
            case (r_phase)
                PH_LEAD: begin
                    if (blank || c == CH_PLUS) begin
                        n_phase = PH_LEAD;
                    end else if (c == CH_MINUS) begin
                        n_neg = !r_neg;
                    end else if (c == CH_ZERO) begin
                        n_phase = PH_ZERO1;
                    end else begin
                        body = 1'b1;
                    end
                end
                PH_ZERO1: begin
                    if (c == CH_X) begin
                        n_phase = PH_X;
                    end else if (c == CH_ZERO) begin
                        n_phase = PH_ZEROS;
                    end else begin
                        body = 1'b1;
                    end
                end
                PH_X, PH_ZEROS: begin
                    if (c == CH_ZERO) begin
                        n_phase = PH_ZEROS;
                    end else begin
                        body = 1'b1;
                    end
                end
                PH_BODY: begin
                    body = 1'b1;
                end
                PH_AFTER: begin
                    if (blank) begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
            // significant digits, 'h' terminator, or an error
            if (body) begin
                if (blank) begin
                    n_failed = 1'b1;
                end else if (c == CH_H) begin
                    n_phase = PH_AFTER;
                end else if (!hx.is_hex || r_count >= CNT_W'(MAX_DIGITS)) begin
                    n_failed = 1'b1;
                end else begin
                    n_acc   = {r_acc[VALUE_W-5:0], hx.digit};
                    n_count = r_count + 1'b1;
                    n_phase = PH_BODY;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_neg    <= 1'b0;
            r_acc    <= '0;
            r_count  <= '0;
            r_failed <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_acc    <= n_acc;
            r_count  <= n_count;
            r_failed <= n_failed;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/htoi_out_stage.sv -----
// Result register of the parser: holds one result item until the sink
// takes it. Depends on htoi_pkg.
`default_nettype none

module htoi_out_stage
    import htoi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_free,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- rtl/core/hex_text_to_integer.sv -----
// A terminator item's result passes from the input register to the result register,
// where the sink can take it.
// Throughput: one item per cycle while no result is stalled; the one-character state update between
// the input register and the result register sets that figure.
// A terminator waits in the input register only while a result is stalled.
// Reset (synchronous, active low) empties both registers and the parse state.
// Depends on htoi_pkg, htoi_if, htoi_in_stage, htoi_parse, htoi_out_stage.
`default_nettype none

module hex_text_to_integer
    import htoi_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    htoi_in_if.sink     i_in,
    htoi_out_if.source  o_out
);

    t_item   in_item;
    t_item   st_item;
    logic    st_valid;
    logic    advance;
    logic    out_free;
    t_result parse_res;
    t_result out_res;

    assign in_item.character  = i_in.character;
    assign in_item.terminator = i_in.terminator;

    // a terminator moves on only when the result register can take it
    assign advance = st_valid && (!st_item.terminator || out_free);

    htoi_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (i_in.ready),
        .o_valid   (st_valid),
        .o_item    (st_item)
    );

    htoi_parse #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (st_item),
        .o_result (parse_res)
    );

    htoi_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && st_item.terminator),
        .i_result (parse_res),
        .i_ready  (o_out.ready),
        .o_free   (out_free),
        .o_valid  (o_out.valid),
        .o_result (out_res)
    );

    assign o_out.value = out_res.value;
    assign o_out.ok    = out_res.ok;

endmodule

`default_nettype wire

// ----- rtl/core/htoi_checker.sv -----
// Port-level checks for hex_text_to_integer, attached by bind.
// Depends on the top level's ports only.
`default_nettype none

module htoi_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_term,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_out_value,
    input wire logic        i_out_ok
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
                                        && $stable(i_out_ok))
        else $error("result item changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ok |-> i_out_value == 64'd0)
        else $error("failed parse gave a nonzero value");

    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_rise_from_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_term, 2))
        else $error("result item without a terminator two cycles before");

endmodule

bind hex_text_to_integer htoi_checker u_htoi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_term   (i_in.terminator),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value),
    .i_out_ok    (o_out.ok)
);

`default_nettype wire
